// File: rtl/fqd_pkg.sv
// Package for the FIFO queue with delete by value.
// Holds sizes, operation and status codes and the cell control struct.
// No dependencies.
package fqd_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_DEL  = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic in_use;
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

// File: rtl/fqd_req_if.sv
// Request channel of the FIFO queue: operation code and operand word.
// Depends on fqd_pkg.
interface fqd_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic signed [fqd_pkg::DATA_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

// File: rtl/fqd_rsp_if.sv
// Response channel of the FIFO queue: status, head and entry count.
// Depends on fqd_pkg.
interface fqd_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic signed [fqd_pkg::DATA_W-1:0] head_value;
    logic                              head_valid;
    logic [fqd_pkg::CNT_W-1:0]         count;

    modport source (output valid, output status, output head_value, output head_valid,
                    output count, input ready);
    modport sink (input valid, input status, input head_value, input head_valid,
                  input count, output ready);
endinterface

// File: rtl/fqd_cell.sv
// One queue slot: holds an entry, compares it with the operand word,
// loads a pushed word or takes its neighbour's entry. Depends on fqd_pkg.
module fqd_cell (
    input  logic                           clk,
    input  fqd_pkg::cell_ctrl_t            ctrl,
    input  logic [fqd_pkg::DATA_W-1:0]     value,
    input  logic [fqd_pkg::DATA_W-1:0]     neighbour,
    output logic [fqd_pkg::DATA_W-1:0]     entry,
    output logic [fqd_pkg::DATA_W-1:0]     entry_next,
    output logic                           match
);

    logic [fqd_pkg::DATA_W-1:0] entry_reg;

    assign entry = entry_reg;
    assign match = ctrl.in_use && (entry_reg == value);

    always_comb
    begin
        if (ctrl.load)
        begin
            entry_next = value;
        end
        else if (ctrl.shift)
        begin
            entry_next = neighbour;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: rtl/fifo_queue_with_delete_by_value_unit.sv
// Top level of the FIFO queue with delete by value; depends on fqd_pkg,
// fqd_req_if, fqd_rsp_if and fqd_cell.
// The response to an accepted word is in the output register in the next cycle. One
// word per cycle when the response side does not stall; all cells compare and shift at once.
// Reset: rst_n clears the entry count and the response valid; entries stay undefined.
module fifo_queue_with_delete_by_value_unit (
    input  logic       clk,
    input  logic       rst_n,
    fqd_req_if.sink    req,
    fqd_rsp_if.source  rsp
);

    localparam int DEPTH = fqd_pkg::DEPTH;
    localparam int CNT_W = fqd_pkg::CNT_W;
    localparam int DATA_W = fqd_pkg::DATA_W;

    logic [CNT_W-1:0]            occ_reg;
    logic [CNT_W-1:0]            occ_next;
    logic                        rsp_valid_reg;
    logic [1:0]                  status_reg;
    logic [1:0]                  status_next;
    logic [DATA_W-1:0]           head_reg;
    logic                        head_valid_reg;

    logic                        accept;
    logic                        full;
    logic                        empty;
    logic                        is_push;
    logic                        is_pop;
    logic                        is_del;
    logic [DEPTH-1:0]            match;
    logic [DEPTH-1:0]            found;
    logic [DATA_W-1:0]           entry      [DEPTH];
    logic [DATA_W-1:0]           entry_next [DEPTH];
    fqd_pkg::cell_ctrl_t         ctrl       [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (occ_reg == CNT_W'(DEPTH));
    assign empty     = (occ_reg == '0);
    assign is_push   = (req.mode == fqd_pkg::MODE_PUSH);
    assign is_pop    = (req.mode == fqd_pkg::MODE_POP);
    assign is_del    = (req.mode == fqd_pkg::MODE_DEL);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(g);

            assign ctrl[g].in_use = (IDX < occ_reg);
            assign ctrl[g].load   = accept && is_push && !full && (occ_reg == IDX);
            assign ctrl[g].shift  = accept && ((is_pop && !empty) || (is_del && found[g]));

            if (g == 0)
            begin : g_first
                assign found[g] = match[g];
            end
            else
            begin : g_rest
                assign found[g] = found[g-1] | match[g];
            end

            if (g == DEPTH - 1)
            begin : g_last
                fqd_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl[g]),
                    .value      (req.value),
                    .neighbour  (entry[g]),
                    .entry      (entry[g]),
                    .entry_next (entry_next[g]),
                    .match      (match[g])
                );
            end
            else
            begin : g_mid
                fqd_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl[g]),
                    .value      (req.value),
                    .neighbour  (entry[g+1]),
                    .entry      (entry[g]),
                    .entry_next (entry_next[g]),
                    .match      (match[g])
                );
            end
        end
    endgenerate

    always_comb
    begin
        occ_next    = occ_reg;
        status_next = fqd_pkg::ST_DONE;
        if (is_push)
        begin
            if (full)
            begin
                status_next = fqd_pkg::ST_FULL;
            end
            else
            begin
                occ_next = occ_reg + CNT_W'(1);
            end
        end
        else if (is_pop || is_del)
        begin
            if (empty)
            begin
                status_next = fqd_pkg::ST_EMPTY;
            end
            else if (is_del && !found[DEPTH-1])
            begin
                status_next = fqd_pkg::ST_NOTFOUND;
            end
            else
            begin
                occ_next = occ_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                occ_reg       <= occ_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            head_valid_reg <= (occ_next != '0);
            head_reg       <= (occ_next != '0) ? entry_next[0] : '0;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.head_value = head_reg;
    assign rsp.head_valid = head_valid_reg;
    assign rsp.count      = occ_reg;

`ifndef NO_ASSERTIONS
    a_occ_bound : assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_head_flag : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (head_valid_reg == (occ_reg != '0)))
        else $error("head flag disagrees with count");

    a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == fqd_pkg::ST_FULL) |-> occ_reg == CNT_W'(DEPTH))
        else $error("full status with room left");

    a_occ_step : assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(occ_reg))
        else $error("count moved without a word");
`endif

endmodule
